// ===== rtl/pteg_pkg.sv =====
// shared types, constants and grading function of the pixel time event grader
package pteg_pkg;

    localparam int COLUMNS_DEF   = 32;
    localparam int ROWS_DEF      = 32;
    localparam int TIME_BITS_DEF = 48;

    localparam int PORT_TIME_W = 48;
    localparam int MAX_TIME_W  = 64;
    localparam int COORD_W     = 5;
    localparam int WIN_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int GRADE_W     = 2;
    localparam int ST_W        = 4;

    localparam int ST_SEEN = 0;
    localparam int ST_PEND = 1;
    localparam int ST_NEAR = 2;
    localparam int ST_PILE = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PRE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PILEUP = 2'd2;

    localparam logic [GRADE_W-1:0] GRADE_CLEAN  = 2'd0;
    localparam logic [GRADE_W-1:0] GRADE_LATER  = 2'd1;
    localparam logic [GRADE_W-1:0] GRADE_NEAR   = 2'd2;
    localparam logic [GRADE_W-1:0] GRADE_PILEUP = 2'd3;

    typedef enum logic {
        OP_EVENT = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        logic [WIN_W-1:0] pre;
        logic [WIN_W-1:0] post;
        logic [WIN_W-1:0] pileup;
    } t_windows;

    function automatic logic [GRADE_W-1:0] grade_of(
        input logic near_before,
        input logic pile_before,
        input logic any_after,
        input logic near_after,
        input logic pile_after
    );
        logic [GRADE_W-1:0] g;
        if (pile_before || pile_after) begin
            g = GRADE_PILEUP;
        end else if (near_before || near_after) begin
            g = GRADE_NEAR;
        end else if (!any_after) begin
            g = GRADE_CLEAN;
        end else begin
            g = GRADE_LATER;
        end
        return g;
    endfunction

endpackage

// ===== rtl/pixel_time_event_grader_core.sv =====
// top level of the pixel time event grader: window registers and pixel store
// Each accepted transaction (i_start high while o_busy is low) goes in order
// through accept with the pixel store read issued, read data and time
// difference, then grading with the write back of the pixel's status and,
// for an event, its time; o_busy stays high until that read-modify-write of
// the per-pixel memories is done. A final grade appears on the result ports
// for exactly one cycle, marked by o_result_valid, in the cycle after the
// update; it cannot be stalled and must be taken then. After reset the status
// memory is cleared one entry a cycle, all COLUMNS*ROWS (1024 by default),
// with o_busy high. Window registers are written through the configuration
// channel, which is always ready; write them only while the block is idle.
module pixel_time_event_grader_core import pteg_pkg::*; #(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_operation,
    input  logic [PORT_TIME_W-1:0] i_event_time,
    input  logic [COORD_W-1:0]     i_pixel_col,
    input  logic [COORD_W-1:0]     i_pixel_row,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WIN_W-1:0]       i_cfg_data,
    output logic                   o_result_valid,
    output logic [PORT_TIME_W-1:0] o_graded_time,
    output logic [COORD_W-1:0]     o_graded_col,
    output logic [COORD_W-1:0]     o_graded_row,
    output logic [GRADE_W-1:0]     o_grade
);

    localparam int DEPTH = COLUMNS * ROWS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_windows               r_win;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic                   time_we;
    logic [TIME_BITS-1:0]   time_wdata;
    logic [TIME_BITS-1:0]   time_rdata;
    logic                   stat_we;
    logic [ST_W-1:0]        stat_wdata;
    logic [ST_W-1:0]        stat_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PRE:    r_win.pre    <= i_cfg_data;
                CFG_POST:   r_win.post   <= i_cfg_data;
                CFG_PILEUP: r_win.pileup <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pteg_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (wr_addr),
        .i_wdata (time_wdata),
        .i_raddr (rd_addr),
        .o_rdata (time_rdata)
    );

    pteg_ram #(
        .WIDTH (ST_W),
        .DEPTH (DEPTH)
    ) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (stat_we),
        .i_waddr (wr_addr),
        .i_wdata (stat_wdata),
        .i_raddr (rd_addr),
        .o_rdata (stat_rdata)
    );

    pteg_ctrl #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_operation    (i_operation),
        .i_event_time   (i_event_time),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_win          (r_win),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_time_we      (time_we),
        .o_time_wdata   (time_wdata),
        .i_time_rdata   (time_rdata),
        .o_stat_we      (stat_we),
        .o_stat_wdata   (stat_wdata),
        .i_stat_rdata   (stat_rdata),
        .o_result_valid (o_result_valid),
        .o_graded_time  (o_graded_time),
        .o_graded_col   (o_graded_col),
        .o_graded_row   (o_graded_row),
        .o_grade        (o_grade)
    );

endmodule

// ===== rtl/pteg_ram.sv =====
// generic single write port ram with registered read
module pteg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pteg_ctrl.sv =====
// sequencer and datapath: pixel store read, grading and write back
module pteg_ctrl import pteg_pkg::*; #(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam int DEPTH = COLUMNS * ROWS,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_operation,
    input  logic [PORT_TIME_W-1:0] i_event_time,
    input  logic [COORD_W-1:0]     i_pixel_col,
    input  logic [COORD_W-1:0]     i_pixel_row,
    input  t_windows               i_win,
    output logic [IDX_W-1:0]       o_rd_addr,
    output logic [IDX_W-1:0]       o_wr_addr,
    output logic                   o_time_we,
    output logic [TIME_BITS-1:0]   o_time_wdata,
    input  logic [TIME_BITS-1:0]   i_time_rdata,
    output logic                   o_stat_we,
    output logic [ST_W-1:0]        o_stat_wdata,
    input  logic [ST_W-1:0]        i_stat_rdata,
    output logic                   o_result_valid,
    output logic [PORT_TIME_W-1:0] o_graded_time,
    output logic [COORD_W-1:0]     o_graded_col,
    output logic [COORD_W-1:0]     o_graded_row,
    output logic [GRADE_W-1:0]     o_grade
);

    localparam int CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_UPDATE
    } t_state;

    t_state                 r_state;
    logic [IDX_W-1:0]       r_clr;
    logic                   r_result_valid;
    logic [PORT_TIME_W-1:0] r_graded_time;
    logic [COORD_W-1:0]     r_graded_col;
    logic [COORD_W-1:0]     r_graded_row;
    logic [GRADE_W-1:0]     r_grade;

    logic                   r_op;
    logic [TIME_BITS-1:0]   r_time;
    logic [COORD_W-1:0]     r_col;
    logic [COORD_W-1:0]     r_row;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_in_range;
    logic [ST_W-1:0]        r_stat;
    logic [TIME_BITS-1:0]   r_last;
    logic [TIME_BITS-1:0]   r_diff;

    logic [31:0]            idx_full;
    logic [IDX_W-1:0]       in_idx;
    logic                   in_range;
    logic [MAX_TIME_W-1:0]  in_time_wide;
    logic [MAX_TIME_W-1:0]  last_wide;
    logic [CMP_W-1:0]       diff_c;
    logic                   seen;
    logic                   pend;
    logic                   any_a;
    logic                   near_a;
    logic                   pile_a;
    logic                   upd_valid;
    logic [GRADE_W-1:0]     upd_grade;
    logic                   accept;

    assign accept       = i_start && (r_state == S_IDLE);
    assign idx_full     = 32'(i_pixel_row) * 32'(COLUMNS) + 32'(i_pixel_col);
    assign in_idx       = idx_full[IDX_W-1:0];
    assign in_range     = (32'(i_pixel_col) < 32'(COLUMNS)) && (32'(i_pixel_row) < 32'(ROWS));
    assign in_time_wide = MAX_TIME_W'(i_event_time);
    assign last_wide    = MAX_TIME_W'(r_last);

    assign diff_c = CMP_W'(r_diff);
    assign seen   = r_stat[ST_SEEN];
    assign pend   = r_stat[ST_PEND];
    assign any_a  = seen && (diff_c <= CMP_W'(i_win.post));
    assign near_a = any_a && (diff_c < CMP_W'(i_win.pre));
    assign pile_a = any_a && (diff_c < CMP_W'(i_win.pileup));

    always_comb begin
        o_time_we    = 1'b0;
        o_stat_we    = 1'b0;
        o_stat_wdata = '0;
        upd_valid    = 1'b0;
        upd_grade    = GRADE_CLEAN;
        unique case (r_state)
            S_CLEAR: begin
                o_stat_we = 1'b1;
            end
            S_UPDATE: begin
                if (t_op'(r_op) == OP_FLUSH) begin
                    o_stat_we    = r_in_range && pend;
                    o_stat_wdata = ST_W'(seen);
                    upd_valid    = r_in_range && pend;
                    upd_grade    = grade_of(r_stat[ST_NEAR], r_stat[ST_PILE],
                                            1'b0, 1'b0, 1'b0);
                end else begin
                    o_time_we    = r_in_range;
                    o_stat_we    = r_in_range;
                    o_stat_wdata = {pile_a, near_a, 1'b1, 1'b1};
                    upd_valid    = r_in_range && seen && pend;
                    upd_grade    = grade_of(r_stat[ST_NEAR], r_stat[ST_PILE],
                                            any_a, near_a, pile_a);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rd_addr    = (r_state == S_IDLE) ? in_idx : r_idx;
    assign o_wr_addr    = (r_state == S_CLEAR) ? r_clr : r_idx;
    assign o_time_wdata = r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= (r_state == S_UPDATE) && upd_valid;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == 32'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_state        <= S_IDLE;
                    r_graded_time  <= last_wide[PORT_TIME_W-1:0];
                    r_graded_col   <= r_col;
                    r_graded_row   <= r_row;
                    r_grade        <= upd_grade;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // transaction capture and read data staging
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_operation;
            r_time     <= in_time_wide[TIME_BITS-1:0];
            r_col      <= i_pixel_col;
            r_row      <= i_pixel_row;
            r_idx      <= in_idx;
            r_in_range <= in_range;
        end
        if (r_state == S_FETCH) begin
            r_stat <= i_stat_rdata;
            r_last <= i_time_rdata;
            r_diff <= (r_time >= i_time_rdata) ? (r_time - i_time_rdata) : '0;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_graded_time  = r_graded_time;
    assign o_graded_col   = r_graded_col;
    assign o_graded_row   = r_graded_row;
    assign o_grade        = r_grade;

endmodule

// ===== dv/pixel_time_event_grader_core_test.sv =====
// testbench for pixel_time_event_grader_core: predicts per-pixel grades and checks every result
module pixel_time_event_grader_core_test import pteg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXELS = COLUMNS_DEF * ROWS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [PORT_TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [PORT_TIME_W-1:0] ev_time;
        logic [COORD_W-1:0]     col;
        logic [COORD_W-1:0]     row;
        logic [GRADE_W-1:0]     grade;
    } t_graded;

    class grade_scoreboard;
        logic [WIN_W-1:0]       pre_w;
        logic [WIN_W-1:0]       post_w;
        logic [WIN_W-1:0]       pile_w;
        logic [PORT_TIME_W-1:0] last_time [PIXELS];
        logic [ST_W-1:0]        status [PIXELS];
        t_graded                expected_q [$];
        int unsigned            failures;

        function new();
            pre_w = '0;
            post_w = '0;
            pile_w = '0;
            failures = 0;
            foreach (status[i]) status[i] = '0;
            foreach (last_time[i]) last_time[i] = '0;
        endfunction

        function void note_window(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
            case (idx)
                CFG_PRE:    pre_w = val;
                CFG_POST:   post_w = val;
                CFG_PILEUP: pile_w = val;
                default: ;
            endcase
        endfunction

        function logic [GRADE_W-1:0] pick_grade(bit near_b, bit pile_b, bit after,
                                                bit near_a, bit pile_a);
            if (pile_b || pile_a) return GRADE_PILEUP;
            if (near_b || near_a) return GRADE_NEAR;
            return after ? GRADE_LATER : GRADE_CLEAN;
        endfunction

        function void note_request(t_op op, logic [PORT_TIME_W-1:0] t,
                                   logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
            int unsigned            idx;
            logic [ST_W-1:0]        st;
            logic [PORT_TIME_W-1:0] span;
            bit                     after;
            bit                     near_a;
            bit                     pile_a;
            t_graded                g;
            idx = r * COLUMNS_DEF + c;
            st = status[idx];
            after = 1'b0;
            near_a = 1'b0;
            pile_a = 1'b0;
            g.col = c;
            g.row = r;
            if (op == OP_FLUSH) begin
                if (st[ST_PEND]) begin
                    g.ev_time = last_time[idx];
                    g.grade = pick_grade(st[ST_NEAR], st[ST_PILE], 1'b0, 1'b0, 1'b0);
                    expected_q.push_back(g);
                    status[idx] = '0;
                    status[idx][ST_SEEN] = st[ST_SEEN];
                end
            end else begin
                if (st[ST_SEEN]) begin
                    // time running backwards counts as zero distance
                    span = (t >= last_time[idx]) ? t - last_time[idx] : '0;
                    after = span <= post_w;
                    near_a = after && span < pre_w;
                    pile_a = after && span < pile_w;
                    if (st[ST_PEND]) begin
                        g.ev_time = last_time[idx];
                        g.grade = pick_grade(st[ST_NEAR], st[ST_PILE], after, near_a, pile_a);
                        expected_q.push_back(g);
                    end
                end
                status[idx] = '0;
                status[idx][ST_SEEN] = 1'b1;
                status[idx][ST_PEND] = 1'b1;
                status[idx][ST_NEAR] = near_a;
                status[idx][ST_PILE] = pile_a;
                last_time[idx] = t;
            end
        endfunction

        function void check_result(t_graded got);
            t_graded want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result time %h col %0d row %0d grade %0d",
                             $time, got.ev_time, got.col, got.row, got.grade);
                return;
            end
            want = expected_q.pop_front();
            if (got.ev_time !== want.ev_time || got.col !== want.col ||
                got.row !== want.row || got.grade !== want.grade) begin
                failures++;
                if (failures <= 10)
                    $display({"%0t: mismatch expected time %h col %0d row %0d grade %0d,",
                              " got time %h col %0d row %0d grade %0d"},
                             $time, want.ev_time, want.col, want.row, want.grade,
                             got.ev_time, got.col, got.row, got.grade);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_start;
    logic                   o_busy;
    logic                   i_operation;
    logic [PORT_TIME_W-1:0] i_event_time;
    logic [COORD_W-1:0]     i_pixel_col;
    logic [COORD_W-1:0]     i_pixel_row;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [WIN_W-1:0]       i_cfg_data;
    logic                   o_result_valid;
    logic [PORT_TIME_W-1:0] o_graded_time;
    logic [COORD_W-1:0]     o_graded_col;
    logic [COORD_W-1:0]     o_graded_row;
    logic [GRADE_W-1:0]     o_grade;

    grade_scoreboard sb = new();

    logic [PORT_TIME_W-1:0] stream_time;
    logic [COORD_W-1:0]     pool_col [4];
    logic [COORD_W-1:0]     pool_row [4];
    logic [COORD_W-1:0]     last_col;
    logic [COORD_W-1:0]     last_row;

    pixel_time_event_grader_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_operation    (i_operation),
        .i_event_time   (i_event_time),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_graded_time  (o_graded_time),
        .o_graded_col   (o_graded_col),
        .o_graded_row   (o_graded_row),
        .o_grade        (o_grade)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("pixel_time_event_grader_core_test failed");
        $finish;
    end

    // results first, then the transaction accepted at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid === 1'b1)
                sb.check_result('{o_graded_time, o_graded_col, o_graded_row, o_grade});
            if (i_start && o_busy === 1'b0)
                sb.note_request(t_op'(i_operation), i_event_time, i_pixel_col, i_pixel_row);
            if (i_cfg_valid && o_cfg_ready === 1'b1)
                sb.note_window(i_cfg_index, i_cfg_data);
        end
    end

    task automatic send_request(t_op op, logic [PORT_TIME_W-1:0] t,
                                logic [COORD_W-1:0] c, logic [COORD_W-1:0] r, bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_operation <= op;
        i_event_time <= t;
        i_pixel_col <= c;
        i_pixel_row <= r;
        do @(posedge i_clk); while (o_busy !== 1'b0);
    endtask

    task automatic end_requests();
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic settle();
        end_requests();
        while (sb.expected_q.size() != 0 || o_busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_windows(logic [WIN_W-1:0] pre, logic [WIN_W-1:0] post,
                               logic [WIN_W-1:0] pile);
        settle();
        write_window(CFG_PRE, pre);
        write_window(CFG_POST, post);
        write_window(CFG_PILEUP, pile);
        // spare index must leave the windows alone
        write_window(CFG_SPARE, $urandom);
    endtask

    task automatic random_request(bit may_idle);
        logic [63:0]            w;
        logic [63:0]            delta;
        logic [63:0]            ahead;
        logic [PORT_TIME_W-1:0] t;
        logic [COORD_W-1:0]     c;
        logic [COORD_W-1:0]     r;
        t_op                    op;
        int                     pick;
        int                     k;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            c = last_col;
            r = last_row;
        end else if (pick < 9) begin
            k = $urandom_range(0, 3);
            c = pool_col[k];
            r = pool_row[k];
        end else begin
            c = $urandom_range(0, 31);
            r = $urandom_range(0, 31);
        end
        last_col = c;
        last_row = r;
        op = ($urandom_range(0, 99) < 15) ? OP_FLUSH : OP_EVENT;
        case ($urandom_range(0, 2))
            0:       w = {32'd0, sb.pre_w};
            1:       w = {32'd0, sb.post_w};
            default: w = {32'd0, sb.pile_w};
        endcase
        // steps around the window edges
        case ($urandom_range(0, 6))
            0:       delta = '0;
            1:       delta = (w == 0) ? '0 : w - 1;
            2:       delta = w;
            3:       delta = w + 1;
            4, 5:    delta = {$urandom, $urandom} % (w + 1);
            default: delta = ($urandom_range(0, 3) == 0) ?
                             {24'd0, 8'($urandom), $urandom} : 64'($urandom_range(0, 20));
        endcase
        ahead = {16'd0, stream_time} + delta;
        stream_time = (ahead > {16'd0, TIME_MAX}) ? TIME_MAX : ahead[PORT_TIME_W-1:0];
        if (op == OP_FLUSH)
            t = {16'($urandom), $urandom};
        else if ($urandom_range(0, 99) < 3)
            t = stream_time - ((stream_time < 50) ? stream_time : $urandom_range(1, 50));
        else
            t = stream_time;
        send_request(op, t, c, r, may_idle);
    endtask

    task automatic run_phase(int n, bit may_idle);
        foreach (pool_col[i]) begin
            pool_col[i] = $urandom_range(0, 31);
            pool_row[i] = $urandom_range(0, 31);
        end
        last_col = pool_col[0];
        last_row = pool_row[0];
        repeat (n) random_request(may_idle);
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_operation = 1'b0;
        i_event_time = '0;
        i_pixel_col = '0;
        i_pixel_row = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        stream_time = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // status store clears itself after reset
        do @(posedge i_clk); while (o_busy !== 1'b0);

        set_windows(32'd100, 32'd1000, 32'd10);
        send_request(OP_FLUSH, '0, 5'd0, 5'd0, 1'b0);
        send_request(OP_EVENT, 48'd0, 5'd0, 5'd0, 1'b0);
        send_request(OP_EVENT, 48'd5, 5'd0, 5'd0, 1'b1);
        send_request(OP_EVENT, 48'd55, 5'd0, 5'd0, 1'b0);
        send_request(OP_EVENT, 48'd555, 5'd0, 5'd0, 1'b1);
        send_request(OP_EVENT, 48'd5555, 5'd0, 5'd0, 1'b0);
        send_request(OP_FLUSH, TIME_MAX, 5'd0, 5'd0, 1'b0);
        send_request(OP_FLUSH, '0, 5'd0, 5'd0, 1'b0);
        send_request(OP_EVENT, 48'd5600, 5'd0, 5'd0, 1'b0);
        send_request(OP_EVENT, 48'd5600, 5'd31, 5'd31, 1'b0);
        send_request(OP_EVENT, 48'd6600, 5'd31, 5'd31, 1'b1);
        send_request(OP_EVENT, 48'd5000, 5'd0, 5'd0, 1'b0);
        send_request(OP_EVENT, 48'd6009, 5'd0, 5'd0, 1'b0);
        send_request(OP_FLUSH, 48'h5555_aaaa_5555, 5'd31, 5'd31, 1'b0);
        send_request(OP_EVENT, 48'd6610, 5'd31, 5'd31, 1'b0);
        send_request(OP_EVENT, 48'd6620, 5'd31, 5'd31, 1'b0);
        send_request(OP_FLUSH, 48'haaaa_5555_aaaa, 5'd31, 5'd31, 1'b1);
        stream_time = 48'd7000;

        set_windows('0, '0, '0);
        run_phase(65, 1'b1);
        set_windows('1, '1, '1);
        run_phase(65, 1'b1);
        set_windows($urandom_range(0, 200), $urandom_range(0, 1000), $urandom_range(0, 50));
        run_phase(65, 1'b1);
        set_windows($urandom, $urandom, $urandom);
        run_phase(65, 1'b1);
        set_windows('1, $urandom_range(0, 500), '0);
        run_phase(65, 1'b1);

        // top of the time range, no idling
        set_windows($urandom_range(0, 300), $urandom_range(0, 2000), $urandom_range(0, 100));
        stream_time = TIME_MAX - 48'h10_0000;
        run_phase(60, 1'b0);
        send_request(OP_EVENT, TIME_MAX, 5'd31, 5'd0, 1'b0);
        send_request(OP_EVENT, TIME_MAX, 5'd31, 5'd0, 1'b0);
        send_request(OP_FLUSH, '0, 5'd31, 5'd0, 1'b0);
        end_requests();

        for (waited = 0; waited < 200 && sb.expected_q.size() != 0; waited++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $display("%0d expected results never arrived", sb.expected_q.size());
            sb.failures += sb.expected_q.size();
        end
        if (sb.failures == 0) begin
            $display("pixel_time_event_grader_core_test passed");
        end else begin
            $display("pixel_time_event_grader_core_test failed");
        end
        $finish;
    end

endmodule
